[hdl/clx_pkg.sv]
// shared types, token codes and character classes for the lexer
package clx_pkg;

	typedef enum logic [10:0] {
		M_IDLE       = 11'b000_0000_0001,
		M_IDENT      = 11'b000_0000_0010,
		M_INT        = 11'b000_0000_0100,
		M_REAL_DOT   = 11'b000_0000_1000,
		M_REAL_FRAC  = 11'b000_0001_0000,
		M_SLASH      = 11'b000_0010_0000,
		M_OP         = 11'b000_0100_0000,
		M_LINE_CMT   = 11'b000_1000_0000,
		M_BLOCK      = 11'b001_0000_0000,
		M_BLOCK_STAR = 11'b010_0000_0000,
		M_HALTED     = 11'b100_0000_0000
	} mode_t;

	typedef struct packed {
		logic [5:0]  tok_class;
		logic [15:0] start_line;
		logic [15:0] start_column;
		logic [15:0] tok_len;
		logic        error_seen;
		logic        last_of_run;
	} tok_t;

	localparam logic [5:0] K_END   = 6'd0;
	localparam logic [5:0] K_IDENT = 6'd1;
	localparam logic [5:0] K_INT   = 6'd2;
	localparam logic [5:0] K_REAL  = 6'd3;
	localparam logic [5:0] K_KW0   = 6'd4;
	localparam logic [5:0] K_SLASH = 6'd17;

	localparam logic [2:0] OP_NONE = 3'd0;
	localparam logic [2:0] OP_LT   = 3'd1;
	localparam logic [2:0] OP_GT   = 3'd2;
	localparam logic [2:0] OP_EQ   = 3'd3;
	localparam logic [2:0] OP_NOT  = 3'd4;
	localparam logic [2:0] OP_AND  = 3'd5;
	localparam logic [2:0] OP_OR   = 3'd6;

	localparam int NUM_KW = 10;
	localparam logic [47:0] KW_TEXT [NUM_KW] = '{
		48'h0000_0069_6e74, 48'h0066_6c6f_6174, 48'h0000_626f_6f6c, 48'h0000_766f_6964,
		48'h7265_7475_726e, 48'h0000_0000_6966, 48'h0000_656c_7365, 48'h0077_6869_6c65,
		48'h0000_7472_7565, 48'h0066_616c_7365
	};
	localparam logic [2:0] KW_LEN [NUM_KW] = '{
		3'd3, 3'd5, 3'd4, 3'd4, 3'd6, 3'd2, 3'd4, 3'd5, 3'd4, 3'd5
	};

	function automatic logic is_alpha(input logic [7:0] c);
		return (c >= 8'h61 && c <= 8'h7a) || (c >= 8'h41 && c <= 8'h5a);
	endfunction

	function automatic logic is_digit(input logic [7:0] c);
		return c >= 8'h30 && c <= 8'h39;
	endfunction

	function automatic logic is_space(input logic [7:0] c);
		return c == 8'h20 || (c >= 8'h09 && c <= 8'h0d);
	endfunction

	function automatic logic [2:0] op_code(input logic [7:0] c);
		case (c)
			8'h3c:   return OP_LT;
			8'h3e:   return OP_GT;
			8'h3d:   return OP_EQ;
			8'h21:   return OP_NOT;
			8'h26:   return OP_AND;
			8'h7c:   return OP_OR;
			default: return OP_NONE;
		endcase
	endfunction

	function automatic logic [7:0] op_second(input logic [2:0] p);
		case (p)
			OP_AND:  return 8'h26;
			OP_OR:   return 8'h7c;
			default: return 8'h3d;
		endcase
	endfunction

	function automatic logic [5:0] op_single(input logic [2:0] p);
		case (p)
			OP_LT:   return 6'd19;
			OP_GT:   return 6'd20;
			OP_EQ:   return 6'd18;
			OP_NOT:  return 6'd21;
			default: return K_END;
		endcase
	endfunction

	function automatic logic [5:0] op_double(input logic [2:0] p);
		case (p)
			OP_LT:   return 6'd22;
			OP_GT:   return 6'd23;
			OP_EQ:   return 6'd24;
			OP_NOT:  return 6'd25;
			OP_AND:  return 6'd26;
			OP_OR:   return 6'd27;
			default: return K_END;
		endcase
	endfunction

	function automatic logic [5:0] single_kind(input logic [7:0] c);
		case (c)
			8'h2b:         return 6'd14;
			8'h2d:         return 6'd15;
			8'h2a:         return 6'd16;
			8'h3b:         return 6'd28;
			8'h2c, 8'h3a:  return 6'd29;
			8'h28:         return 6'd30;
			8'h29:         return 6'd31;
			8'h7b:         return 6'd32;
			8'h7d:         return 6'd33;
			8'h5b:         return 6'd34;
			8'h5d:         return 6'd35;
			default:       return K_END;
		endcase
	endfunction

endpackage

[hdl/clx_if.sv]
// request channels for source bytes and tokens
interface clx_byte_if;
	logic       valid;
	logic       ready;
	logic [7:0] source_byte;
	logic       byte_valid;
	logic       end_of_source;
	modport source (output valid, source_byte, byte_valid, end_of_source, input ready);
	modport sink (input valid, source_byte, byte_valid, end_of_source, output ready);
endinterface

interface clx_tok_if;
	logic        valid;
	logic        ready;
	logic [5:0]  tok_class;
	logic [15:0] start_line;
	logic [15:0] start_column;
	logic [15:0] tok_len;
	logic        error_seen;
	logic        last_of_run;
	modport source (output valid, tok_class, start_line, start_column, tok_len,
		error_seen, last_of_run, input ready);
	modport sink (input valid, tok_class, start_line, start_column, tok_len,
		error_seen, last_of_run, output ready);
endinterface

[hdl/clx_step.sv]
// lexer state and combinational next-state and token logic
module clx_step import clx_pkg::*; #(
	parameter int COUNT_BITS = 16
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       take,
	input  logic [7:0] source_byte,
	input  logic       byte_valid,
	input  logic       end_of_source,
	output tok_t       res [3],
	output logic [1:0] res_n
);

	localparam int CB = COUNT_BITS;
	localparam int W = (CB > 16) ? CB : 16;
	localparam logic [CB-1:0] ONE = CB'(1);

	mode_t          mode_q, m;
	logic [47:0]    prefix_q, pre;
	logic [CB-1:0]  run_q, rl;
	logic [CB-1:0]  tcol_q, tc;
	logic [CB-1:0]  line_q, ln;
	logic [CB-1:0]  col_q, cl;
	logic [2:0]     pend_q, po;
	logic           err_q, er;
	logic [1:0]     n;
	logic           do_idle, is_end, go;
	logic [7:0]     c;
	logic [5:0]     k;

	function automatic logic [15:0] clamp(input logic [CB-1:0] v);
		logic [W-1:0] e;
		e = W'(v);
		return (e > W'(17'hffff)) ? 16'hffff : e[15:0];
	endfunction

	function automatic logic [CB-1:0] sat_inc(input logic [CB-1:0] v);
		return (v == {CB{1'b1}}) ? v : v + ONE;
	endfunction

	function automatic logic [5:0] word_kind(input logic [47:0] p, input logic [CB-1:0] l);
		logic [5:0] r;
		r = K_IDENT;
		if (l <= CB'(6)) begin
			for (int i = 0; i < NUM_KW; i++) begin
				if (p == KW_TEXT[i] && l == CB'(KW_LEN[i]))
					r = K_KW0 + 6'(i);
			end
		end
		return r;
	endfunction

	always_comb begin
		m = mode_q; pre = prefix_q; rl = run_q; tc = tcol_q;
		ln = line_q; cl = col_q; po = pend_q; er = err_q;
		n = 2'd0; do_idle = 1'b0; k = K_END;
		for (int i = 0; i < 3; i++) res[i] = '0;
		c = source_byte;
		is_end = end_of_source || (byte_valid && c == 8'h00);
		go = byte_valid && c != 8'h00;
		if (go) begin
			case (m)
				M_IDENT: begin
					if (is_alpha(c) || is_digit(c) || c == 8'h5f) begin
						if (rl < CB'(6)) pre = {pre[39:0], c};
						rl = sat_inc(rl); cl = sat_inc(cl);
					end else begin
						res[n] = '{word_kind(pre, rl), clamp(ln), clamp(tc), clamp(rl), er, 1'b0};
						n = n + 2'd1; do_idle = 1'b1;
					end
				end
				M_INT: begin
					if (is_digit(c)) begin
						rl = sat_inc(rl); cl = sat_inc(cl);
					end else if (c == 8'h2e) begin
						rl = sat_inc(rl); cl = sat_inc(cl); m = M_REAL_DOT;
					end else begin
						res[n] = '{K_INT, clamp(ln), clamp(tc), clamp(rl), er, 1'b0};
						n = n + 2'd1; do_idle = 1'b1;
					end
				end
				M_REAL_DOT: begin
					if (is_digit(c)) begin
						rl = sat_inc(rl); cl = sat_inc(cl); m = M_REAL_FRAC;
					end else begin
						er = 1'b1; m = M_HALTED;
					end
				end
				M_REAL_FRAC: begin
					if (is_digit(c)) begin
						rl = sat_inc(rl); cl = sat_inc(cl);
					end else begin
						res[n] = '{K_REAL, clamp(ln), clamp(tc), clamp(rl), er, 1'b0};
						n = n + 2'd1; do_idle = 1'b1;
					end
				end
				M_SLASH: begin
					if (c == 8'h2f) begin
						cl = sat_inc(cl); m = M_LINE_CMT;
					end else if (c == 8'h2a) begin
						cl = sat_inc(cl); m = M_BLOCK;
					end else begin
						res[n] = '{K_SLASH, clamp(ln), clamp(tc), 16'd1, er, 1'b0};
						n = n + 2'd1; do_idle = 1'b1;
					end
				end
				M_OP: begin
					if (po != OP_NONE && c == op_second(po)) begin
						res[n] = '{op_double(po), clamp(ln), clamp(tc), 16'd2, er, 1'b0};
						n = n + 2'd1;
						cl = sat_inc(cl); po = OP_NONE; m = M_IDLE;
					end else begin
						if (op_single(po) == K_END) er = 1'b1;
						res[n] = '{op_single(po), clamp(ln), clamp(tc), 16'd1, er, 1'b0};
						n = n + 2'd1; po = OP_NONE; do_idle = 1'b1;
					end
				end
				M_LINE_CMT: begin
					if (c != 8'h0a) cl = sat_inc(cl);
					else do_idle = 1'b1;
				end
				M_BLOCK, M_BLOCK_STAR: begin
					if (c == 8'h0a) begin
						ln = sat_inc(ln); cl = ONE; m = M_BLOCK;
					end else begin
						cl = sat_inc(cl);
						if (m == M_BLOCK_STAR && c == 8'h2f) m = M_IDLE;
						else m = (c == 8'h2a) ? M_BLOCK_STAR : M_BLOCK;
					end
				end
				M_HALTED: ;
				default: do_idle = 1'b1;
			endcase
			if (do_idle) begin
				m = M_IDLE; rl = '0; pre = '0;
				if (is_space(c)) begin
					if (c == 8'h0a) begin
						ln = sat_inc(ln); cl = ONE;
					end else cl = sat_inc(cl);
				end else if (c == 8'h2f || is_alpha(c) || c == 8'h5f || is_digit(c)
						|| op_code(c) != OP_NONE) begin
					if (c == 8'h2f) m = M_SLASH;
					else if (is_alpha(c) || c == 8'h5f) begin
						m = M_IDENT; pre = {40'd0, c};
					end else if (is_digit(c)) m = M_INT;
					else begin
						m = M_OP; po = op_code(c);
					end
					tc = cl; rl = ONE; cl = sat_inc(cl);
				end else begin
					k = single_kind(c);
					if (k == K_END) er = 1'b1;
					res[n] = '{k, clamp(ln), clamp(cl), 16'd1, er, 1'b0};
					n = n + 2'd1;
					cl = sat_inc(cl);
				end
			end
		end
		if (is_end) begin
			case (m)
				M_IDENT: begin
					res[n] = '{word_kind(pre, rl), clamp(ln), clamp(tc), clamp(rl), er, 1'b0};
					n = n + 2'd1;
				end
				M_INT: begin
					res[n] = '{K_INT, clamp(ln), clamp(tc), clamp(rl), er, 1'b0};
					n = n + 2'd1;
				end
				M_REAL_FRAC: begin
					res[n] = '{K_REAL, clamp(ln), clamp(tc), clamp(rl), er, 1'b0};
					n = n + 2'd1;
				end
				M_SLASH: begin
					res[n] = '{K_SLASH, clamp(ln), clamp(tc), 16'd1, er, 1'b0};
					n = n + 2'd1;
				end
				M_OP: begin
					if (op_single(po) == K_END) er = 1'b1;
					res[n] = '{op_single(po), clamp(ln), clamp(tc), 16'd1, er, 1'b0};
					n = n + 2'd1;
				end
				M_REAL_DOT, M_BLOCK, M_BLOCK_STAR: er = 1'b1;
				default: ;
			endcase
			res[n] = '{K_END, clamp(ln), clamp(cl), 16'd0, er, 1'b0};
			n = n + 2'd1;
			m = M_IDLE; pre = '0; rl = '0; tc = ONE; ln = ONE; cl = ONE;
			po = OP_NONE; er = 1'b0;
		end
		if (n != 2'd0) res[n - 2'd1].last_of_run = 1'b1;
		res_n = n;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q   <= M_IDLE;
			prefix_q <= '0;
			run_q    <= '0;
			tcol_q   <= ONE;
			line_q   <= ONE;
			col_q    <= ONE;
			pend_q   <= OP_NONE;
			err_q    <= 1'b0;
		end else if (take) begin
			mode_q   <= m;
			prefix_q <= pre;
			run_q    <= rl;
			tcol_q   <= tc;
			line_q   <= ln;
			col_q    <= cl;
			pend_q   <= po;
			err_q    <= er;
		end
	end

endmodule

[hdl/clx_outbuf.sv]
// result register holding the tokens of one request and draining them in order
module clx_outbuf import clx_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       load,
	input  tok_t       res [3],
	input  logic [1:0] res_n,
	input  logic       pop,
	output tok_t       head,
	output logic [1:0] count
);

	tok_t       slot_q [3];
	logic [1:0] cnt_q, idx_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= 2'd0;
			idx_q <= 2'd0;
		end else if (load) begin
			cnt_q <= res_n;
			idx_q <= 2'd0;
		end else if (pop) begin
			cnt_q <= cnt_q - 2'd1;
			idx_q <= idx_q + 2'd1;
		end
	end

	always_ff @(posedge clk) begin
		if (load) slot_q <= res;
	end

	assign head  = (idx_q < 2'd3) ? slot_q[idx_q] : slot_q[0];
	assign count = cnt_q;

endmodule

[hdl/c_subset_lexer.sv]
// top level of the streaming lexer
// latency: the first token of a request is offered the cycle after the request that completes it
// throughput: one byte request per cycle while each request yields at most one token
//   and the token sink is ready; a request yielding two or three tokens holds input
//   until its last token is taken; the three-slot result register sets this figure
// reset: asynchronous, clears lexer state and drops all buffered tokens
module c_subset_lexer import clx_pkg::*; #(
	parameter int COUNT_BITS = 16
) (
	input  logic        clk,
	input  logic        arst_n,
	clx_byte_if.sink    src,
	clx_tok_if.source   tok
);

	tok_t       res [3];
	tok_t       head;
	logic [1:0] res_n, count;
	logic       take, pop;

	assign pop       = tok.valid && tok.ready;
	assign src.ready = (count == 2'd0) || (count == 2'd1 && tok.ready);
	assign take      = src.valid && src.ready;

	clx_step #(.COUNT_BITS(COUNT_BITS)) u_step (
		.clk(clk), .arst_n(arst_n), .take(take),
		.source_byte(src.source_byte), .byte_valid(src.byte_valid),
		.end_of_source(src.end_of_source), .res(res), .res_n(res_n)
	);

	clx_outbuf u_buf (
		.clk(clk), .arst_n(arst_n), .load(take), .res(res), .res_n(res_n),
		.pop(pop), .head(head), .count(count)
	);

	assign tok.valid        = count != 2'd0;
	assign tok.tok_class    = head.tok_class;
	assign tok.start_line   = head.start_line;
	assign tok.start_column = head.start_column;
	assign tok.tok_len      = head.tok_len;
	assign tok.error_seen   = head.error_seen;
	assign tok.last_of_run  = head.last_of_run;

	a_last: assert property (@(posedge clk) disable iff (!arst_n)
		tok.valid && count == 2'd1 |-> tok.last_of_run) else $error("last token unmarked");
	a_end: assert property (@(posedge clk) disable iff (!arst_n)
		take && src.end_of_source |=> tok.valid) else $error("end token missing");
	a_len: assert property (@(posedge clk) disable iff (!arst_n)
		tok.valid && tok.tok_len == 16'd0 |-> tok.tok_class == K_END)
		else $error("empty token not end");

endmodule
